FILE: design/epvad_pkg.sv
package epvad_pkg;

   localparam int MAX_WINDOW = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int RUN_BITS = 24;

   localparam int WINDOW_BITS = $clog2(MAX_WINDOW) + 1;
   localparam int COUNT_BITS = $clog2(MAX_WINDOW);
   localparam int MAG_BITS = SAMPLE_BITS;
   localparam int SQ_BITS = 2 * MAG_BITS;
   localparam int SUM_BITS = SQ_BITS + COUNT_BITS - 1;
   localparam int ETHR_BITS = 31;
   localparam int PTHR_BITS = 16;
   localparam int PROD_BITS = ETHR_BITS + WINDOW_BITS;

   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 5;
   localparam int REG_INDEX_BITS = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_FILL_BITS = QUEUE_PTR_BITS + 1;

   localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

   localparam logic [WINDOW_BITS-1:0] RESET_WINDOW_LENGTH = WINDOW_BITS'(160);
   localparam logic [ETHR_BITS-1:0] RESET_ENERGY_THRESHOLD = ETHR_BITS'(1073742);
   localparam logic [PTHR_BITS-1:0] RESET_PEAK_THRESHOLD = PTHR_BITS'(328);
   localparam logic [RUN_BITS-1:0] RESET_MIN_SOUND = RUN_BITS'(1600);
   localparam logic [RUN_BITS-1:0] RESET_MIN_SILENCE = RUN_BITS'(800);
   localparam logic [RUN_BITS-1:0] RESET_HANGOVER = RUN_BITS'(1600);

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_WINDOW_LENGTH = 3'd0,
      REG_ENERGY_THRESHOLD = 3'd1,
      REG_PEAK_THRESHOLD = 3'd2,
      REG_MIN_SOUND = 3'd3,
      REG_MIN_SILENCE = 3'd4,
      REG_HANGOVER = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [WINDOW_BITS-1:0] window_length;
      logic [ETHR_BITS-1:0] energy_threshold;
      logic [PTHR_BITS-1:0] peak_threshold;
      logic [RUN_BITS-1:0] min_sound_samples;
      logic [RUN_BITS-1:0] min_silence_samples;
      logic [RUN_BITS-1:0] hang_samples;
   } cfg_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      logic [MAG_BITS-1:0] peak;
      logic [WINDOW_BITS-1:0] count;
   } window_rec_type;

   typedef struct packed {
      logic push;
      window_rec_type rec;
   } queue_push_type;

   typedef struct packed {
      logic [QUEUE_FILL_BITS-1:0] fill;
      window_rec_type head;
   } queue_status_type;

endpackage

FILE: design/epvad_if.sv
interface epvad_req_if;
   logic valid;
   logic ready;
   logic signed [epvad_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface epvad_rsp_if;
   logic valid;
   logic ready;
   logic window_active;
   logic in_segment;
   logic segment_start;
   logic segment_end;
   logic collect_window;
   logic [epvad_pkg::MAG_BITS-1:0] window_peak;

   modport source (output valid, output window_active, output in_segment,
                   output segment_start, output segment_end,
                   output collect_window, output window_peak, input ready);
   modport sink (input valid, input window_active, input in_segment,
                 input segment_start, input segment_end,
                 input collect_window, input window_peak, output ready);
endinterface

FILE: design/epvad_csr.sv
module epvad_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [epvad_pkg::ADDR_BITS-1:0] paddr,
   input  logic [epvad_pkg::DATA_BITS-1:0] pwdata,
   output logic [epvad_pkg::DATA_BITS-1:0] prdata,
   output logic pready,
   output epvad_pkg::cfg_type cfg
);

   epvad_pkg::cfg_type cfg_ff;
   epvad_pkg::cfg_type cfg_in;
   epvad_pkg::reg_index_type index;
   logic write_en;

   assign index = epvad_pkg::reg_index_type'(paddr[epvad_pkg::ADDR_BITS-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            epvad_pkg::REG_WINDOW_LENGTH:
               cfg_in.window_length = pwdata[epvad_pkg::WINDOW_BITS-1:0];
            epvad_pkg::REG_ENERGY_THRESHOLD:
               cfg_in.energy_threshold = pwdata[epvad_pkg::ETHR_BITS-1:0];
            epvad_pkg::REG_PEAK_THRESHOLD:
               cfg_in.peak_threshold = pwdata[epvad_pkg::PTHR_BITS-1:0];
            epvad_pkg::REG_MIN_SOUND:
               cfg_in.min_sound_samples = pwdata[epvad_pkg::RUN_BITS-1:0];
            epvad_pkg::REG_MIN_SILENCE:
               cfg_in.min_silence_samples = pwdata[epvad_pkg::RUN_BITS-1:0];
            epvad_pkg::REG_HANGOVER:
               cfg_in.hang_samples = pwdata[epvad_pkg::RUN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         epvad_pkg::REG_WINDOW_LENGTH:
            prdata = epvad_pkg::DATA_BITS'(cfg_ff.window_length);
         epvad_pkg::REG_ENERGY_THRESHOLD:
            prdata = epvad_pkg::DATA_BITS'(cfg_ff.energy_threshold);
         epvad_pkg::REG_PEAK_THRESHOLD:
            prdata = epvad_pkg::DATA_BITS'(cfg_ff.peak_threshold);
         epvad_pkg::REG_MIN_SOUND:
            prdata = epvad_pkg::DATA_BITS'(cfg_ff.min_sound_samples);
         epvad_pkg::REG_MIN_SILENCE:
            prdata = epvad_pkg::DATA_BITS'(cfg_ff.min_silence_samples);
         epvad_pkg::REG_HANGOVER:
            prdata = epvad_pkg::DATA_BITS'(cfg_ff.hang_samples);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= epvad_pkg::RESET_WINDOW_LENGTH;
         cfg_ff.energy_threshold <= epvad_pkg::RESET_ENERGY_THRESHOLD;
         cfg_ff.peak_threshold <= epvad_pkg::RESET_PEAK_THRESHOLD;
         cfg_ff.min_sound_samples <= epvad_pkg::RESET_MIN_SOUND;
         cfg_ff.min_silence_samples <= epvad_pkg::RESET_MIN_SILENCE;
         cfg_ff.hang_samples <= epvad_pkg::RESET_HANGOVER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/epvad_front.sv
module epvad_front (
   input  logic clock,
   input  logic reset,
   epvad_req_if.sink req_ch,
   input  logic [epvad_pkg::WINDOW_BITS-1:0] window_length,
   input  logic [epvad_pkg::QUEUE_FILL_BITS-1:0] queue_fill,
   output epvad_pkg::queue_push_type push
);

   localparam logic [epvad_pkg::WINDOW_BITS-1:0] MAX_LEN =
      epvad_pkg::WINDOW_BITS'(epvad_pkg::MAX_WINDOW);
   localparam logic [epvad_pkg::QUEUE_FILL_BITS:0] DEPTH =
      (epvad_pkg::QUEUE_FILL_BITS+1)'(epvad_pkg::QUEUE_DEPTH);

   logic a_valid_ff, a_valid_in;
   logic a_last_ff, a_last_in;
   logic [epvad_pkg::SQ_BITS-1:0] a_sq_ff, a_sq_in;
   logic [epvad_pkg::MAG_BITS-1:0] a_mag_ff, a_mag_in;
   logic [epvad_pkg::WINDOW_BITS-1:0] a_count_ff, a_count_in;
   logic [epvad_pkg::COUNT_BITS-1:0] samples_ff, samples_in;
   logic [epvad_pkg::SUM_BITS-1:0] acc_sum_ff, acc_sum_in;
   logic [epvad_pkg::MAG_BITS-1:0] acc_peak_ff, acc_peak_in;

   logic accept;
   logic [epvad_pkg::SAMPLE_BITS-1:0] raw;
   logic [epvad_pkg::WINDOW_BITS-1:0] eff_len;
   logic [epvad_pkg::WINDOW_BITS-1:0] count;
   logic [epvad_pkg::QUEUE_FILL_BITS:0] committed;
   logic [epvad_pkg::SUM_BITS-1:0] sum_next;
   logic [epvad_pkg::MAG_BITS-1:0] peak_next;

   assign committed = {1'b0, queue_fill} +
                      (epvad_pkg::QUEUE_FILL_BITS+1)'(a_valid_ff && a_last_ff);
   assign req_ch.ready = committed < DEPTH;
   assign accept = req_ch.valid && req_ch.ready;
   assign raw = req_ch.sample;

   always_comb begin
      eff_len = window_length;
      if (window_length == '0) begin
         eff_len = epvad_pkg::WINDOW_BITS'(1);
      end else if (window_length > MAX_LEN) begin
         eff_len = MAX_LEN;
      end
   end

   assign count = epvad_pkg::WINDOW_BITS'(samples_ff) + epvad_pkg::WINDOW_BITS'(1);

   always_comb begin
      a_valid_in = accept;
      a_last_in = count >= eff_len;
      a_count_in = count;
      a_mag_in = raw[epvad_pkg::SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
      a_sq_in = epvad_pkg::SQ_BITS'(a_mag_in) * epvad_pkg::SQ_BITS'(a_mag_in);
      samples_in = samples_ff;
      if (accept) begin
         samples_in = a_last_in ? '0 : count[epvad_pkg::COUNT_BITS-1:0];
      end
   end

   assign sum_next = acc_sum_ff + epvad_pkg::SUM_BITS'(a_sq_ff);
   assign peak_next = (a_mag_ff > acc_peak_ff) ? a_mag_ff : acc_peak_ff;

   always_comb begin
      acc_sum_in = acc_sum_ff;
      acc_peak_in = acc_peak_ff;
      push.push = a_valid_ff && a_last_ff;
      push.rec.sum = sum_next;
      push.rec.peak = peak_next;
      push.rec.count = a_count_ff;
      if (a_valid_ff) begin
         acc_sum_in = a_last_ff ? '0 : sum_next;
         acc_peak_in = a_last_ff ? '0 : peak_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         samples_ff <= '0;
         acc_sum_ff <= '0;
         acc_peak_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         samples_ff <= samples_in;
         acc_sum_ff <= acc_sum_in;
         acc_peak_ff <= acc_peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_last_ff <= a_last_in;
         a_count_ff <= a_count_in;
         a_mag_ff <= a_mag_in;
         a_sq_ff <= a_sq_in;
      end
   end

endmodule

FILE: design/epvad_queue.sv
module epvad_queue (
   input  logic clock,
   input  logic reset,
   input  epvad_pkg::queue_push_type push,
   input  logic pop,
   output epvad_pkg::queue_status_type status
);

   epvad_pkg::window_rec_type mem [epvad_pkg::QUEUE_DEPTH];
   logic [epvad_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [epvad_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [epvad_pkg::QUEUE_FILL_BITS-1:0] fill_ff, fill_in;

   assign status.fill = fill_ff;
   assign status.head = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in = fill_ff + epvad_pkg::QUEUE_FILL_BITS'(push.push)
                - epvad_pkg::QUEUE_FILL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem[wr_ptr_ff] <= push.rec;
      end
   end

endmodule

FILE: design/epvad_back.sv
module epvad_back (
   input  logic clock,
   input  logic reset,
   input  epvad_pkg::cfg_type cfg,
   input  epvad_pkg::queue_status_type status,
   output logic pop,
   epvad_rsp_if.source rsp_ch
);

   logic en;

   logic s1_valid_ff, s1_valid_in;
   logic [epvad_pkg::SUM_BITS-1:0] s1_sum_ff;
   logic [epvad_pkg::MAG_BITS-1:0] s1_peak_ff;
   logic [epvad_pkg::WINDOW_BITS-1:0] s1_count_ff;
   logic [epvad_pkg::PROD_BITS-1:0] s1_prod_ff, s1_prod_in;

   logic [epvad_pkg::RUN_BITS-1:0] sound_ff, sound_in;
   logic [epvad_pkg::RUN_BITS-1:0] silence_ff, silence_in;
   logic open_ff, open_in;

   logic out_valid_ff, out_valid_in;
   logic active_ff, start_ff, end_ff, collect_ff, in_seg_ff;
   logic [epvad_pkg::MAG_BITS-1:0] peak_ff;

   logic active, start, stop, collect, step;
   logic [epvad_pkg::RUN_BITS:0] snd_add, sil_add;
   logic [epvad_pkg::RUN_BITS-1:0] snd_sat, sil_sat;

   assign en = !out_valid_ff || rsp_ch.ready;
   assign pop = en && (status.fill != '0);
   assign step = en && s1_valid_ff;
   assign s1_valid_in = en ? pop : s1_valid_ff;
   assign out_valid_in = en ? s1_valid_ff : out_valid_ff;
   assign s1_prod_in = epvad_pkg::PROD_BITS'(cfg.energy_threshold)
                       * epvad_pkg::PROD_BITS'(status.head.count);

   assign snd_add = {1'b0, sound_ff} + (epvad_pkg::RUN_BITS+1)'(s1_count_ff);
   assign sil_add = {1'b0, silence_ff} + (epvad_pkg::RUN_BITS+1)'(s1_count_ff);
   assign snd_sat = snd_add[epvad_pkg::RUN_BITS] ? epvad_pkg::RUN_MAX
                                                 : snd_add[epvad_pkg::RUN_BITS-1:0];
   assign sil_sat = sil_add[epvad_pkg::RUN_BITS] ? epvad_pkg::RUN_MAX
                                                 : sil_add[epvad_pkg::RUN_BITS-1:0];

   always_comb begin
      active = (epvad_pkg::PROD_BITS'(s1_sum_ff) > s1_prod_ff)
               || (s1_peak_ff > cfg.peak_threshold);
      start = 1'b0;
      stop = 1'b0;
      open_in = open_ff;
      if (active) begin
         sound_in = snd_sat;
         silence_in = '0;
         if (!open_ff && snd_sat >= cfg.min_sound_samples) begin
            open_in = 1'b1;
            start = 1'b1;
         end
      end else begin
         silence_in = sil_sat;
         sound_in = '0;
         if (open_ff && sil_sat >= cfg.min_silence_samples) begin
            open_in = 1'b0;
            stop = 1'b1;
            silence_in = '0;
         end
      end
      collect = open_in ||
                ((silence_in != '0) && (silence_in <= cfg.hang_samples));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         sound_ff <= '0;
         silence_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            sound_ff <= sound_in;
            silence_ff <= silence_in;
            open_ff <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_sum_ff <= status.head.sum;
         s1_peak_ff <= status.head.peak;
         s1_count_ff <= status.head.count;
         s1_prod_ff <= s1_prod_in;
      end
      if (step) begin
         active_ff <= active;
         in_seg_ff <= open_in;
         start_ff <= start;
         end_ff <= stop;
         collect_ff <= collect;
         peak_ff <= s1_peak_ff;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.window_active = active_ff;
   assign rsp_ch.in_segment = in_seg_ff;
   assign rsp_ch.segment_start = start_ff;
   assign rsp_ch.segment_end = end_ff;
   assign rsp_ch.collect_window = collect_ff;
   assign rsp_ch.window_peak = peak_ff;

endmodule

FILE: design/energy_peak_voice_activity_detector.sv
// Energy and peak voice activity detector. Takes one signed Q1.15 sample per request and
// returns one result per completed window of window_length samples (zero acts as one,
// values above 4096 saturate): the activity flag, segment state, segment start and end,
// the collect flag for segment or hangover, and the window's peak magnitude. A window
// is active when its sum of squares exceeds energy_threshold times its sample count or
// its peak exceeds peak_threshold; sound and silence runs saturate at 2^24-1. The block
// accepts one sample every clock cycle while the window queue has room. A window's result
// passes the accumulate register, the queue, then the threshold product and run update
// registers. A four-entry window queue separates sample intake from the segment logic, so
// a stalled result side stops intake only once that queue is full. The user must write
// configuration through the APB port while no window is in flight; the block does not enforce it.
module energy_peak_voice_activity_detector (
   input  logic clock,
   input  logic reset,
   epvad_req_if.sink req_ch,
   epvad_rsp_if.source rsp_ch,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [epvad_pkg::ADDR_BITS-1:0] paddr,
   input  logic [epvad_pkg::DATA_BITS-1:0] pwdata,
   output logic [epvad_pkg::DATA_BITS-1:0] prdata,
   output logic pready
);

   epvad_pkg::cfg_type cfg;
   epvad_pkg::queue_push_type push;
   epvad_pkg::queue_status_type status;
   logic pop;

   epvad_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   epvad_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .window_length (cfg.window_length),
      .queue_fill    (status.fill),
      .push          (push)
   );

   epvad_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   epvad_back u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .status (status),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import epvad_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int LATENCY_SLACK = 10;
   localparam int DRAIN_LIMIT = 200000;
   localparam logic [REG_INDEX_BITS-1:0] REG_UNMAPPED_LOW = 3'd6;
   localparam logic [REG_INDEX_BITS-1:0] REG_UNMAPPED_HIGH = 3'd7;
   localparam logic [DATA_BITS-1:0] FULL_SCALE_SQ = 32'h4000_0000;
   localparam logic [DATA_BITS-1:0] FULL_SCALE = 32'h0000_8000;

   typedef enum {SOUND_QUIET, SOUND_LOUD, SOUND_NOISE} sound_kind_type;

   typedef struct packed {
      logic active;
      logic in_segment;
      logic opened;
      logic closed;
      logic collect;
      logic [MAG_BITS-1:0] peak;
   } window_verdict_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_BITS-1:0] paddr;
   logic [DATA_BITS-1:0] pwdata;
   logic [DATA_BITS-1:0] prdata;
   logic pready;
   logic receiver_hold = 1'b0;

   epvad_req_if req_if();
   epvad_rsp_if rsp_if();

   energy_peak_voice_activity_detector dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if.sink),
      .rsp_ch(rsp_if.source),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // detector model: configuration and window state
   logic [WINDOW_BITS-1:0] wl_cfg;
   logic [ETHR_BITS-1:0] ethr_cfg;
   logic [PTHR_BITS-1:0] pthr_cfg;
   logic [RUN_BITS-1:0] min_sound_cfg;
   logic [RUN_BITS-1:0] min_silence_cfg;
   logic [RUN_BITS-1:0] hang_cfg;
   int unsigned window_fill;
   longint unsigned energy_sum;
   int unsigned peak_acc;
   int unsigned sound_run;
   int unsigned silence_run;
   bit segment_open;

   window_verdict_type window_verdicts[$];

   int idle_pct = 0;
   int stall_pct = 0;
   int fail_count = 0;
   int samples_sent = 0;
   int windows_checked = 0;
   int opens_seen = 0;
   int closes_seen = 0;
   int hangover_seen = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("mismatch at window %0d: %s", windows_checked, msg);
   endtask

   task automatic check_field(input string name, input logic [MAG_BITS-1:0] got,
                              input logic [MAG_BITS-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic int unsigned window_span();
      if (wl_cfg == 0) return 1;
      if (wl_cfg > MAX_WINDOW) return MAX_WINDOW;
      return wl_cfg;
   endfunction

   function automatic int unsigned saturating_run(input int unsigned run, input int unsigned n);
      return (run + n > RUN_MAX) ? RUN_MAX : run + n;
   endfunction

   function automatic bit judge_sample(input logic [SAMPLE_BITS-1:0] raw,
                                       output window_verdict_type v);
      int unsigned mag;
      int unsigned taken;
      mag = raw[SAMPLE_BITS-1] ? (32'h10000 - raw) : raw;
      energy_sum += mag * mag;
      if (mag > peak_acc) peak_acc = mag;
      taken = window_fill + 1;
      v = '0;
      if (taken < window_span()) begin
         window_fill = taken;
         return 1'b0;
      end
      v.active = (energy_sum > longint'(ethr_cfg) * taken) || (peak_acc > pthr_cfg);
      if (v.active) begin
         sound_run = saturating_run(sound_run, taken);
         silence_run = 0;
         if (!segment_open && sound_run >= min_sound_cfg) begin
            segment_open = 1'b1;
            v.opened = 1'b1;
         end
      end else begin
         silence_run = saturating_run(silence_run, taken);
         sound_run = 0;
         if (segment_open && silence_run >= min_silence_cfg) begin
            segment_open = 1'b0;
            v.closed = 1'b1;
            silence_run = 0;
         end
      end
      v.in_segment = segment_open;
      v.collect = segment_open || (silence_run != 0 && silence_run <= hang_cfg);
      v.peak = peak_acc[MAG_BITS-1:0];
      window_fill = 0;
      energy_sum = 0;
      peak_acc = 0;
      return 1'b1;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] make_sample(input sound_kind_type kind);
      int unsigned lo;
      int unsigned mag;
      int unsigned qmax;
      case (kind)
         SOUND_NOISE: return SAMPLE_BITS'($urandom);
         SOUND_LOUD: begin
            lo = (pthr_cfg >= 16'h8000) ? 32768 : pthr_cfg + 1;
            mag = $urandom_range(32768, lo);
         end
         default: begin
            qmax = (pthr_cfg >= 15 && ethr_cfg >= 225) ? 15 : 0;
            mag = $urandom_range(qmax, 0);
         end
      endcase
      if ($urandom_range(1) == 1) return SAMPLE_BITS'(-int'(mag));
      return SAMPLE_BITS'(mag);
   endfunction

   task automatic write_register(input logic [REG_INDEX_BITS-1:0] index,
                                 input logic [DATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_WINDOW_LENGTH: wl_cfg = value[WINDOW_BITS-1:0];
         REG_ENERGY_THRESHOLD: ethr_cfg = value[ETHR_BITS-1:0];
         REG_PEAK_THRESHOLD: pthr_cfg = value[PTHR_BITS-1:0];
         REG_MIN_SOUND: min_sound_cfg = value[RUN_BITS-1:0];
         REG_MIN_SILENCE: min_silence_cfg = value[RUN_BITS-1:0];
         REG_HANGOVER: hang_cfg = value[RUN_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [DATA_BITS-1:0] wl, input logic [DATA_BITS-1:0] ethr,
                               input logic [DATA_BITS-1:0] pthr,
                               input logic [DATA_BITS-1:0] snd,
                               input logic [DATA_BITS-1:0] sil,
                               input logic [DATA_BITS-1:0] hang);
      write_register(REG_WINDOW_LENGTH, wl);
      write_register(REG_ENERGY_THRESHOLD, ethr);
      write_register(REG_PEAK_THRESHOLD, pthr);
      write_register(REG_MIN_SOUND, snd);
      write_register(REG_MIN_SILENCE, sil);
      write_register(REG_HANGOVER, hang);
   endtask

   task automatic apply_random_config();
      int pick;
      logic [DATA_BITS-1:0] wl;
      pick = $urandom_range(99);
      if (pick < 75) wl = $urandom_range(8, 1);
      else if (pick < 92) wl = $urandom_range(40, 9);
      else wl = 0;
      apply_config(wl, (32'd1 << $urandom_range(29, 8)) | $urandom_range(255, 0),
                   $urandom_range(30000, 16), $urandom_range(24, 0),
                   $urandom_range(24, 0), $urandom_range(40, 0));
   endtask

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
      window_verdict_type v;
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= value;
      do @(posedge clock); while (!req_if.ready);
      samples_sent++;
      if (judge_sample(value, v)) window_verdicts.insert(window_verdicts.size(), v);
   endtask

   task automatic drain_windows();
      int waited;
      req_if.valid <= 1'b0;
      waited = 0;
      while (window_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   task automatic run_sound_mix(input int goal);
      int first;
      int pick;
      int len;
      sound_kind_type kind;
      first = samples_sent;
      while (samples_sent - first < goal) begin
         pick = $urandom_range(99);
         kind = (pick < 15) ? SOUND_NOISE : ((pick < 58) ? SOUND_LOUD : SOUND_QUIET);
         len = window_span() * $urandom_range(4, 1);
         // cut some bursts short so windows straddle sound and silence
         if ($urandom_range(9) == 0) len = $urandom_range(len, 1);
         repeat (len) send_sample(make_sample(kind));
      end
   endtask

   task automatic test_reset_values();
      repeat (80) send_sample(make_sample(SOUND_LOUD));
      repeat (80) send_sample(make_sample(SOUND_QUIET));
      drain_windows();
   endtask

   task automatic test_threshold_edges();
      apply_config(0, FULL_SCALE_SQ, FULL_SCALE, 2, 2, 3);
      write_register(REG_UNMAPPED_LOW, $urandom);
      write_register(REG_UNMAPPED_HIGH, $urandom);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      drain_windows();
      apply_config(0, FULL_SCALE_SQ - 1, FULL_SCALE, 2, 2, 3);
      send_sample(16'h8000);
      send_sample(16'h5555);
      send_sample(16'h8000);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(16'h0000);
      send_sample(16'hAAAA);
      drain_windows();
   endtask

   task automatic test_segment_edges();
      apply_config(1, 0, 0, 0, 0, 0);
      send_sample(16'h0001);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      drain_windows();
   endtask

   task automatic test_window_saturation();
      apply_config(32'h1001, FULL_SCALE_SQ, FULL_SCALE, 1, 1, 1);
      repeat (6) send_sample(16'h8000);
      drain_windows();
      write_register(REG_WINDOW_LENGTH, 32'h1FFF);
      repeat (6) send_sample(16'h8000);
      drain_windows();
      write_register(REG_WINDOW_LENGTH, 1);
      send_sample(16'h8000);
      drain_windows();
   endtask

   task automatic test_window_shrink();
      apply_config(100, 10000, FULL_SCALE, 1, 1, 2);
      repeat (7) send_sample(16'd100);
      drain_windows();
      write_register(REG_WINDOW_LENGTH, 3);
      send_sample(16'd100);
      drain_windows();
      apply_config(100, 9999, FULL_SCALE, 1, 1, 2);
      repeat (4) send_sample(16'd100);
      drain_windows();
      write_register(REG_WINDOW_LENGTH, 0);
      send_sample(16'd100);
      drain_windows();
   endtask

   task automatic test_idle_mixes();
      int idle_mix[4];
      int stall_mix[4];
      idle_mix = '{0, 72, 0, 12};
      stall_mix = '{0, 0, 72, 12};
      for (int p = 0; p < 4; p++) begin
         drain_windows();
         idle_pct = idle_mix[p];
         stall_pct = stall_mix[p];
         case (p)
            1: apply_config(1, 32'h7FFF_FFFF, 32'h0000_FFFF, RUN_MAX, RUN_MAX, RUN_MAX);
            2: apply_config(0, 0, 0, 0, 0, 0);
            default: apply_random_config();
         endcase
         run_sound_mix(90);
      end
      drain_windows();
      idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_receiver_holdoff();
      apply_random_config();
      write_register(REG_WINDOW_LENGTH, 1);
      fork
         begin
            receiver_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            receiver_hold <= 1'b0;
         end
      join_none
      repeat (40) send_sample(make_sample(SOUND_LOUD));
      repeat (40) send_sample(make_sample(SOUND_QUIET));
      drain_windows();
   endtask

   initial begin
      window_verdict_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (window_verdicts.size() == 0) begin
               report_mismatch("result with no window pending");
            end else begin
               want = window_verdicts.pop_front();
               check_field("window_active", MAG_BITS'(rsp_if.window_active),
                           MAG_BITS'(want.active));
               check_field("in_segment", MAG_BITS'(rsp_if.in_segment),
                           MAG_BITS'(want.in_segment));
               check_field("segment_start", MAG_BITS'(rsp_if.segment_start),
                           MAG_BITS'(want.opened));
               check_field("segment_end", MAG_BITS'(rsp_if.segment_end),
                           MAG_BITS'(want.closed));
               check_field("collect_window", MAG_BITS'(rsp_if.collect_window),
                           MAG_BITS'(want.collect));
               check_field("window_peak", rsp_if.window_peak, want.peak);
               opens_seen += want.opened;
               closes_seen += want.closed;
               hangover_seen += (want.collect && !want.in_segment);
            end
            windows_checked++;
         end
         rsp_if.ready <= !receiver_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.sample <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      wl_cfg = RESET_WINDOW_LENGTH;
      ethr_cfg = RESET_ENERGY_THRESHOLD;
      pthr_cfg = RESET_PEAK_THRESHOLD;
      min_sound_cfg = RESET_MIN_SOUND;
      min_silence_cfg = RESET_MIN_SILENCE;
      hang_cfg = RESET_HANGOVER;
      window_fill = 0;
      energy_sum = 0;
      peak_acc = 0;
      sound_run = 0;
      silence_run = 0;
      segment_open = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_threshold_edges();
      test_segment_edges();
      test_window_saturation();
      test_window_shrink();
      test_idle_mixes();
      test_receiver_holdoff();

      drain_windows();
      while (window_verdicts.size() != 0) begin
         void'(window_verdicts.pop_front());
         report_mismatch("window result never arrived");
      end
      $display("covered %0d samples in %0d windows: %0d segment opens, %0d closes, %0d hangover",
               samples_sent, windows_checked, opens_seen, closes_seen, hangover_seen);
      $display("window lengths 0 to 8191, threshold edges, four idle mixes, receiver hold-off");
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
